@@ design/mist_pkg.sv @@
// shared types and constants for the meter id slot table
package mist_pkg;

    localparam int OP_W             = 3;
    localparam int ID_W             = 48;
    localparam int SLOT_W           = 9;
    localparam int LEN_W            = 8;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 10;
    localparam int INSERT_ROW_LIMIT = 29;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_SET_LEN   = 3'd2,
        OP_READ      = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_CLEAR_LEN = 3'd5,
        OP_COUNT     = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_EMPTY     = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_SLOT,
        S_RESP
    } t_state;

    // one table entry as held in memory
    typedef struct packed {
        logic [ID_W-1:0]  meter_id;
        logic             occupied;
        logic [LEN_W-1:0] frame_length;
    } t_entry;

    // one finished result
    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  result_slot;
        logic [ID_W-1:0]    stored_id;
        logic [LEN_W-1:0]   stored_length;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage

@@ design/mist_mem.sv @@
// slot entry memory, one write and one registered read port
module mist_mem
    import mist_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ design/mist_ctrl.sv @@
// request sequencer: clearing pass, table scans and read-modify-write
module mist_ctrl
    import mist_pkg::*;
#(
    parameter int TABLE_COLUMNS = 16,
    parameter int TABLE_ROWS    = 32,
    parameter int SLOT_COUNT    = 512,
    parameter int AW            = 9,
    parameter int CLW           = 4,
    parameter int RW            = 5,
    parameter int CW            = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_meter_id,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [LEN_W-1:0]  i_data_length,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output t_result           o_res,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  t_entry            i_rd_data,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output t_entry            o_wr_data
);

    localparam int INS_ROWS = (INSERT_ROW_LIMIT < TABLE_ROWS) ? INSERT_ROW_LIMIT : TABLE_ROWS;
    localparam logic [AW-1:0]  LAST_ADDR = AW'(SLOT_COUNT - 1);
    localparam logic [CLW-1:0] LAST_COL  = CLW'(TABLE_COLUMNS - 1);
    localparam logic [RW-1:0]  LAST_ROW  = RW'(INS_ROWS - 1);

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CLW-1:0]    r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic              r_issue_done, n_issue_done;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic              r_pend_last, n_pend_last;
    logic [CW-1:0]     r_total, n_total;
    t_result           r_res, n_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_total      <= '0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_pend       <= n_pend;
            r_total      <= n_total;
        end
    end

    // request and scan payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_id        <= n_id;
        r_slot      <= n_slot;
        r_len       <= n_len;
        r_col       <= n_col;
        r_row       <= n_row;
        r_pend_idx  <= n_pend_idx;
        r_pend_last <= n_pend_last;
        r_res       <= n_res;
    end

    // next state, memory accesses and results
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_slot       = r_slot;
        n_len        = r_len;
        n_addr       = r_addr;
        n_col        = r_col;
        n_row        = r_row;
        n_issue_done = r_issue_done;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_pend_last  = r_pend_last;
        n_total      = r_total;
        n_res        = r_res;
        o_ready      = 1'b0;
        o_res_valid  = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_addr;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_pend_idx;
        o_wr_data    = i_rd_data;

        case (r_state)
            // zero every entry after reset
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_addr;
                o_wr_data = '0;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end

            // take a request
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op         = i_operation;
                    n_id         = i_meter_id;
                    n_slot       = i_slot;
                    n_len        = i_data_length;
                    n_addr       = '0;
                    n_col        = '0;
                    n_row        = '0;
                    n_issue_done = 1'b0;
                    n_res        = '0;
                    case (i_operation)
                        OP_LOOKUP, OP_SET_LEN: begin
                            n_state = S_SCAN;
                        end
                        OP_INSERT: begin
                            n_state = S_INSERT;
                        end
                        OP_READ, OP_CLEAR, OP_CLEAR_LEN: begin
                            if (int'(i_slot) >= SLOT_COUNT) begin
                                n_res.status = STATUS_EMPTY;
                                n_state      = S_RESP;
                            end else begin
                                o_rd_en    = 1'b1;
                                o_rd_addr  = AW'(i_slot);
                                n_pend     = 1'b1;
                                n_pend_idx = AW'(i_slot);
                                n_state    = S_SLOT;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // linear scan for the lowest slot holding the matching id
            S_SCAN: begin
                if (!r_issue_done) begin
                    o_rd_en     = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_addr;
                    n_pend_last = (r_addr == LAST_ADDR);
                    if (r_addr == LAST_ADDR) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_pend) begin
                    if (i_rd_data.meter_id == r_id) begin
                        n_res.status        = STATUS_OK;
                        n_res.result_slot   = SLOT_W'(r_pend_idx);
                        n_res.stored_length = i_rd_data.frame_length;
                        if (r_op == OP_SET_LEN) begin
                            o_wr_en                = 1'b1;
                            o_wr_data.frame_length = r_len;
                            n_res.stored_length    = r_len;
                        end
                        n_pend  = 1'b0;
                        n_state = S_RESP;
                    end else if (r_pend_last) begin
                        n_res.status = STATUS_NOT_FOUND;
                        n_pend       = 1'b0;
                        n_state      = S_RESP;
                    end
                end
            end

            // column-interleaved scan for the first free slot
            S_INSERT: begin
                if (!r_issue_done) begin
                    o_rd_en     = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_addr;
                    n_pend_last = (r_col == LAST_COL) && (r_row == LAST_ROW);
                    if ((r_col == LAST_COL) && (r_row == LAST_ROW)) begin
                        n_issue_done = 1'b1;
                    end else if (r_row == LAST_ROW) begin
                        n_row  = '0;
                        n_col  = r_col + CLW'(1);
                        n_addr = AW'(r_col) + AW'(1);
                    end else begin
                        n_row  = r_row + RW'(1);
                        n_addr = r_addr + AW'(TABLE_COLUMNS);
                    end
                end
                if (r_pend) begin
                    if (!i_rd_data.occupied) begin
                        o_wr_en                = 1'b1;
                        o_wr_data.meter_id     = r_id;
                        o_wr_data.occupied     = 1'b1;
                        o_wr_data.frame_length = '0;
                        n_total                = r_total + CW'(1);
                        n_res.status           = STATUS_OK;
                        n_res.result_slot      = SLOT_W'(r_pend_idx);
                        n_pend                 = 1'b0;
                        n_state                = S_RESP;
                    end else if (r_pend_last) begin
                        n_res.status = STATUS_FULL;
                        n_pend       = 1'b0;
                        n_state      = S_RESP;
                    end
                end
            end

            // addressed slot: read, clear or clear length
            S_SLOT: begin
                n_res.result_slot = r_slot;
                case (r_op)
                    OP_READ: begin
                        n_res.stored_length = i_rd_data.frame_length;
                        if (i_rd_data.occupied) begin
                            n_res.status    = STATUS_OK;
                            n_res.stored_id = i_rd_data.meter_id;
                        end else begin
                            n_res.status = STATUS_EMPTY;
                        end
                    end
                    OP_CLEAR: begin
                        o_wr_en   = 1'b1;
                        o_wr_data = '0;
                        if (i_rd_data.occupied && (r_total != '0)) begin
                            n_total = r_total - CW'(1);
                        end
                    end
                    default: begin
                        o_wr_en                = 1'b1;
                        o_wr_data.frame_length = '0;
                    end
                endcase
                n_state = S_RESP;
            end

            // hand the result to the output register
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the count always reflects the table after the request
    always_comb begin
        o_res             = r_res;
        o_res.entry_count = COUNT_W'(r_total);
    end

endmodule

@@ design/meter_id_slot_table.sv @@
// meter id slot table: top level with the result output register
// lookup and set length run a linear scan over every slot
// insert scans up to min(29,TABLE_ROWS) rows of each column; slot read and clears read one slot
// one request in flight, the next taken once its result enters the output register; a full output stalls it
// reset: ready stays low for a clearing pass over every slot
// that zeroes every entry; the occupied count resets to zero
module meter_id_slot_table
    import mist_pkg::*;
#(
    parameter int TABLE_COLUMNS = 16,
    parameter int TABLE_ROWS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_meter_id,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [LEN_W-1:0]  i_data_length,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_result_slot,
    output logic [ID_W-1:0]   o_stored_id,
    output logic              o_has_data,
    output logic [LEN_W-1:0]  o_stored_length,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int SLOT_COUNT = TABLE_COLUMNS * TABLE_ROWS;
    localparam int AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CLW = (TABLE_COLUMNS > 1) ? $clog2(TABLE_COLUMNS) : 1;
    localparam int RW  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CW  = $clog2(SLOT_COUNT + 1);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          res_valid;
    logic          res_take;
    t_result       res;
    logic          r_out_valid;
    t_result       r_out;

    mist_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mist_ctrl #(
        .TABLE_COLUMNS (TABLE_COLUMNS),
        .TABLE_ROWS    (TABLE_ROWS),
        .SLOT_COUNT    (SLOT_COUNT),
        .AW            (AW),
        .CLW           (CLW),
        .RW            (RW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_meter_id    (i_meter_id),
        .i_slot        (i_slot),
        .i_data_length (i_data_length),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    // output register loads a waiting result whenever it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    // result ports
    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_result_slot   = r_out.result_slot;
    assign o_stored_id     = r_out.stored_id;
    assign o_stored_length = r_out.stored_length;
    assign o_has_data      = (r_out.stored_length != '0);
    assign o_entry_count   = r_out.entry_count;

endmodule
